// File: hw/rtl/msra_pkg.sv
// Shared constants, opcodes and types for the register-file ALU block.
// No dependencies; imported by the interfaces and all RTL modules.

package msra_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_W    = $clog2(NUM_REGS);
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int CMD_W    = 3;
	localparam int IMM_W    = 32;
	localparam int STEP_W   = $clog2(DATA_W);

	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADDI = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LI   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_J    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD = 3'd7;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_DIV0   = 1'b1;

	// request from sequencer to the shared arithmetic unit
	typedef struct packed {
		logic              start;
		logic [CMD_W-1:0]  op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] imm;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

	typedef struct packed {
		logic               status;
		logic               wrote;
		logic [REG_W-1:0]   written_reg;
		logic [DATA_W-1:0]  written_value;
		logic [COUNT_W-1:0] instruction_count;
	} out_item_t;

endpackage

// File: hw/rtl/msra_in_if.sv
// Instruction channel: valid/ready handshake plus decoded instruction fields.
// Depends on msra_pkg.

interface msra_in_if import msra_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [REG_W-1:0]        dest_reg;
	logic [REG_W-1:0]        first_source;
	logic [REG_W-1:0]        second_source;
	logic signed [IMM_W-1:0] immediate;

	modport source (output valid, cmd, dest_reg, first_source, second_source, immediate,
		input ready);
	modport sink (input valid, cmd, dest_reg, first_source, second_source, immediate,
		output ready);
endinterface

// File: hw/rtl/msra_out_if.sv
// Result channel: valid/ready handshake plus per-instruction result fields.
// Depends on msra_pkg.

interface msra_out_if import msra_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic                     wrote;
	logic [REG_W-1:0]         written_reg;
	logic signed [DATA_W-1:0] written_value;
	logic [COUNT_W-1:0]       instruction_count;

	modport source (output valid, status, wrote, written_reg, written_value,
		instruction_count, input ready);
	modport sink (input valid, status, wrote, written_reg, written_value,
		instruction_count, output ready);
endinterface

// File: hw/rtl/msra_alu_unit.sv
// Iterative arithmetic unit built around one shared add/subtract adder.
// add/sub/addi/li in one step, mul by shift-add and div by restoring steps.
// Depends on msra_pkg.

module msra_alu_unit import msra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_RUN  = 2'd1;
	localparam logic [1:0] U_FIX  = 2'd2;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

	logic [1:0]        state_q;
	logic              done_q;
	logic [CMD_W-1:0]  op_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] opb_q;
	logic [DATA_W-1:0] opq_q;
	logic [DATA_W-1:0] res_q;
	logic              neg_q;

	logic [DATA_W:0]   add_x;
	logic [DATA_W:0]   add_y;
	logic              add_sub;
	logic [DATA_W+1:0] sum;
	logic [DATA_W:0]   rem_sh;
	logic              no_borrow;
	logic [DATA_W-1:0] quo_next;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	assign mag_a = req.a[DATA_W-1] ? (~req.a + DATA_W'(1)) : req.a;
	assign mag_b = req.b[DATA_W-1] ? (~req.b + DATA_W'(1)) : req.b;

	// partial remainder shifted left by one, next dividend bit in
	assign rem_sh = {acc_q, opq_q[DATA_W-1]};

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		if (state_q == U_FIX) begin
			// final sign fix of the quotient: 0 - q
			add_y   = {1'b0, opq_q};
			add_sub = 1'b1;
		end else begin
			unique case (op_q)
				CMD_ADD, CMD_ADDI, CMD_MUL: begin
					add_x = {1'b0, acc_q};
					add_y = {1'b0, opb_q};
				end
				CMD_SUB: begin
					add_x   = {1'b0, acc_q};
					add_y   = {1'b0, opb_q};
					add_sub = 1'b1;
				end
				CMD_DIV: begin
					add_x   = rem_sh;
					add_y   = {1'b0, opb_q};
					add_sub = 1'b1;
				end
				default: begin
					add_x = '0;
				end
			endcase
		end
	end

	assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
		+ (DATA_W+2)'(add_sub);
	// carry out on a subtract means no borrow
	assign no_borrow = sum[DATA_W+1];
	assign quo_next  = {opq_q[DATA_W-2:0], no_borrow};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					done_q <= 1'b0;
					if (req.start) state_q <= U_RUN;
				end
				U_RUN: begin
					if (op_q == CMD_MUL) begin
						done_q <= (step_q == STEP_LAST);
						if (step_q == STEP_LAST) state_q <= U_IDLE;
					end else if (op_q == CMD_DIV) begin
						done_q <= (step_q == STEP_LAST) && !neg_q;
						if (step_q == STEP_LAST) state_q <= neg_q ? U_FIX : U_IDLE;
					end else begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				U_FIX: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && req.start) begin
			op_q   <= req.op;
			step_q <= '0;
			neg_q  <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
			unique case (req.op)
				CMD_MUL: begin
					acc_q <= '0;
					opb_q <= req.b;
					opq_q <= req.a;
				end
				CMD_DIV: begin
					acc_q <= '0;
					opb_q <= mag_b;
					opq_q <= mag_a;
				end
				CMD_ADDI, CMD_LI: begin
					acc_q <= req.a;
					opb_q <= req.imm;
				end
				default: begin
					acc_q <= req.a;
					opb_q <= req.b;
				end
			endcase
		end else if (state_q == U_RUN) begin
			step_q <= step_q + STEP_W'(1);
			unique case (op_q)
				CMD_ADD, CMD_SUB, CMD_ADDI: res_q <= sum[DATA_W-1:0];
				CMD_LI:                     res_q <= opb_q;
				CMD_MUL: begin
					if (opq_q[0]) acc_q <= sum[DATA_W-1:0];
					opb_q <= opb_q << 1;
					opq_q <= opq_q >> 1;
					res_q <= opq_q[0] ? sum[DATA_W-1:0] : acc_q;
				end
				CMD_DIV: begin
					acc_q <= no_borrow ? sum[DATA_W-1:0] : rem_sh[DATA_W-1:0];
					opq_q <= quo_next;
					res_q <= quo_next;
				end
				default: res_q <= '0;
			endcase
		end else if (state_q == U_FIX) begin
			res_q <= sum[DATA_W-1:0];
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// File: hw/rtl/mips_subset_register_alu.sv
// Each instruction passes S_READ, S_EXEC, S_WAIT and S_DONE; jump, unused opcode and
// divide by zero skip S_WAIT, and a negative quotient adds a sign-fix step. One
// instruction at a time; the next is taken the cycle after the result enters the
// output register. mul and div take one shared-adder step per operand bit.
// Reset (arst_n, async, active low) zeroes all registers and the instruction counter.
// Depends on msra_pkg, msra_in_if, msra_out_if and msra_alu_unit.

module mips_subset_register_alu import msra_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	msra_in_if.sink   instr,
	msra_out_if.source result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [REG_W-1:0]    dest_q;
	logic [REG_W-1:0]    src1_q;
	logic [REG_W-1:0]    src2_q;
	logic [DATA_W-1:0]   imm_q;

	logic [DATA_W-1:0]   rf_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [DATA_W-1:0]   rda_q;
	logic [DATA_W-1:0]   rdb_q;
	logic                rda_vld_q;
	logic                rdb_vld_q;
	logic [DATA_W-1:0]   op_a;
	logic [DATA_W-1:0]   op_b;

	logic [COUNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]  cnt_inc;
	out_item_t           pend_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic                accept;
	logic                exec_skip;
	logic                wr_en;
	logic                load_out;
	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;

	assign accept      = instr.valid && instr.ready;
	assign instr.ready = (state_q == S_IDLE);

	// entries never written since reset read as zero
	assign op_a = rda_vld_q ? rda_q : '0;
	assign op_b = rdb_vld_q ? rdb_q : '0;

	assign exec_skip = (cmd_q == CMD_J) || (cmd_q == CMD_RSVD)
		|| ((cmd_q == CMD_DIV) && (op_b == '0));
	assign wr_en    = (state_q == S_WAIT) && alu_rsp.done;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || result.ready);
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_W'(1);

	assign alu_req.start = (state_q == S_EXEC) && !exec_skip;
	assign alu_req.op    = cmd_q;
	assign alu_req.a     = op_a;
	assign alu_req.b     = op_b;
	assign alu_req.imm   = imm_q;

	msra_alu_unit u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					if (cmd_q == CMD_J) cnt_q <= '0;
					state_q <= exec_skip ? S_DONE : S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						vld_q[dest_q] <= 1'b1;
						cnt_q         <= cnt_inc;
						state_q       <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= instr.cmd;
			dest_q <= instr.dest_reg;
			src1_q <= instr.first_source;
			src2_q <= instr.second_source;
			imm_q  <= DATA_W'(instr.immediate);
		end
		if (state_q == S_READ) begin
			rda_q     <= rf_q[src1_q];
			rdb_q     <= rf_q[src2_q];
			rda_vld_q <= vld_q[src1_q];
			rdb_vld_q <= vld_q[src2_q];
		end
		if (wr_en) rf_q[dest_q] <= alu_rsp.result;

		if (state_q == S_EXEC) begin
			pend_q.wrote         <= 1'b0;
			pend_q.written_reg   <= '0;
			pend_q.written_value <= '0;
			pend_q.status        <= ((cmd_q == CMD_DIV) && (op_b == '0))
				? STATUS_DIV0 : STATUS_OK;
			pend_q.instruction_count <= (cmd_q == CMD_J) ? '0 : cnt_q;
		end else if (wr_en) begin
			pend_q.status            <= STATUS_OK;
			pend_q.wrote             <= 1'b1;
			pend_q.written_reg       <= dest_q;
			pend_q.written_value     <= alu_rsp.result;
			pend_q.instruction_count <= cnt_inc;
		end
		if (load_out) out_q <= pend_q;
	end

	assign result.valid             = out_valid_q;
	assign result.status            = out_q.status;
	assign result.wrote             = out_q.wrote;
	assign result.written_reg       = out_q.written_reg;
	assign result.written_value     = out_q.written_value;
	assign result.instruction_count = out_q.instruction_count;

endmodule

// File: tb/msra_result_checker.sv
// Result checker for mips_subset_register_alu: mirrors the register file and
// counter, predicts each result beat and compares it field by field.
// Depends on msra_pkg, msra_in_if and msra_out_if.

module msra_result_checker import msra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	msra_in_if   instr,
	msra_out_if  result,
	output int   errors,
	output int   outstanding,
	output int   rejected_divs,
	output int   peak_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DATA_W-1:0]  gpr [NUM_REGS];
	logic [COUNT_W-1:0] exec_count;
	out_item_t          pending_results [$];
	out_item_t          head;
	int                 mismatches;
	int                 div0_seen;
	int                 count_peak;

	// signed divide truncating toward zero; MIN / -1 wraps to MIN
	function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] mag_a, mag_b, q;
		mag_a = a[DATA_W-1] ? -a : a;
		mag_b = b[DATA_W-1] ? -b : b;
		q = mag_a / mag_b;
		return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
	endfunction

	// executes one instruction on the mirrored state and returns its result beat
	function automatic out_item_t execute_instr(input logic [CMD_W-1:0] op,
		input logic [REG_W-1:0] rd, input logic [REG_W-1:0] rs,
		input logic [REG_W-1:0] rt, input logic [IMM_W-1:0] imm);
		out_item_t         res;
		logic [DATA_W-1:0] a, b, v;
		logic              w;
		res = '0;
		res.status = STATUS_OK;
		a = gpr[rs];
		b = gpr[rt];
		v = '0;
		w = 1'b0;
		case (op)
			CMD_ADD: begin
				v = a + b;
				w = 1'b1;
			end
			CMD_SUB: begin
				v = a - b;
				w = 1'b1;
			end
			CMD_MUL: begin
				v = a * b;
				w = 1'b1;
			end
			CMD_DIV: begin
				if (b == '0) begin
					res.status = STATUS_DIV0;
					div0_seen++;
				end else begin
					v = trunc_quotient(a, b);
					w = 1'b1;
				end
			end
			CMD_ADDI: begin
				v = a + imm;
				w = 1'b1;
			end
			CMD_LI: begin
				v = imm;
				w = 1'b1;
			end
			CMD_J: exec_count = '0;
			default: ;
		endcase
		if (w) begin
			gpr[rd] = v;
			if (exec_count != '1)
				exec_count++;
		end
		if (int'(exec_count) > count_peak)
			count_peak = int'(exec_count);
		res.wrote             = w;
		res.written_reg       = w ? rd : '0;
		res.written_value     = w ? v : '0;
		res.instruction_count = exec_count;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (gpr[i])
				gpr[i] = '0;
			exec_count = '0;
			pending_results.delete();
			mismatches = 0;
			div0_seen = 0;
			count_peak = 0;
			errors <= 0;
			outstanding <= 0;
			rejected_divs <= 0;
			peak_count <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no instruction pending");
					mismatches++;
				end else begin
					head = pending_results.pop_front();
					compare_field("status", DATA_W'(head.status), DATA_W'(result.status));
					compare_field("wrote", DATA_W'(head.wrote), DATA_W'(result.wrote));
					compare_field("written_reg", DATA_W'(head.written_reg),
						DATA_W'(result.written_reg));
					compare_field("written_value", head.written_value, result.written_value);
					compare_field("instruction_count", DATA_W'(head.instruction_count),
						DATA_W'(result.instruction_count));
				end
			end
			if (instr.valid && instr.ready)
				pending_results.push_back(execute_instr(instr.cmd, instr.dest_reg,
					instr.first_source, instr.second_source, instr.immediate));
			errors <= mismatches;
			outstanding <= pending_results.size();
			rejected_divs <= div0_seen;
			peak_count <= count_peak;
		end
	end

endmodule

// File: tb/tb_mips_subset_register_alu.sv
// Top of the mips_subset_register_alu testbench: clock, reset, instruction stimulus,
// random output back-pressure, watchdog and verdict.
// Depends on msra_pkg, msra_in_if, msra_out_if, the block and msra_result_checker.

module tb_mips_subset_register_alu;
	import msra_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1220;
	// fast instructions sent back to back with no idling on either side
	localparam int BURST_ITEMS    = 200;

	logic clk;
	logic arst_n;
	logic idle_on;
	int   quiet_cycles;
	int   errors, outstanding, rejected_divs, peak_count;
	int   n_items, n_mul, n_div, n_jump;

	msra_in_if  instr_ch ();
	msra_out_if result_ch ();

	mips_subset_register_alu u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	msra_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.instr         (instr_ch),
		.result        (result_ch),
		.errors        (errors),
		.outstanding   (outstanding),
		.rejected_divs (rejected_divs),
		.peak_count    (peak_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk)
		result_ch.ready <= (!idle_on || $urandom_range(99) >= 13);

	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_instr(input logic [CMD_W-1:0] op, input logic [REG_W-1:0] rd,
		input logic [REG_W-1:0] rs, input logic [REG_W-1:0] rt,
		input logic [IMM_W-1:0] imm);
		while (idle_on && $urandom_range(99) < 13) begin
			instr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		instr_ch.valid         <= 1'b1;
		instr_ch.cmd           <= op;
		instr_ch.dest_reg      <= rd;
		instr_ch.first_source  <= rs;
		instr_ch.second_source <= rt;
		instr_ch.immediate     <= imm;
		@(posedge clk);
		while (!instr_ch.ready)
			@(posedge clk);
		n_items++;
		if (op == CMD_MUL)
			n_mul++;
		if (op == CMD_DIV)
			n_div++;
		if (op == CMD_J)
			n_jump++;
	endtask

	// mostly corner values so divides hit zero, -1 and MIN often
	function automatic logic [IMM_W-1:0] pick_operand();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3: return '0;
			4: return 1;
			5: return '1;
			6: return {1'b1, {(IMM_W-1){1'b0}}};
			7: return {1'b0, {(IMM_W-1){1'b1}}};
			default: return $urandom_range(40) - 20;
		endcase
	endfunction

	task automatic send_random(input bit fast_only);
		logic [CMD_W-1:0] op;
		int               r;
		r = $urandom_range(99);
		if (fast_only)
			op = (r < 30) ? CMD_LI : (r < 55) ? CMD_ADDI : (r < 80) ? CMD_ADD : CMD_SUB;
		else if (r < 22)
			op = CMD_LI;
		else if (r < 32)
			op = CMD_ADDI;
		else if (r < 42)
			op = CMD_ADD;
		else if (r < 52)
			op = CMD_SUB;
		else if (r < 65)
			op = CMD_MUL;
		else if (r < 88)
			op = CMD_DIV;
		else if (r < 95)
			op = CMD_J;
		else
			op = CMD_RSVD;
		send_instr(op, REG_W'($urandom_range(NUM_REGS-1)), REG_W'($urandom_range(NUM_REGS-1)),
			REG_W'($urandom_range(NUM_REGS-1)), pick_operand());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		quiet_cycles = 0;
		n_items = 0;
		n_mul = 0;
		n_div = 0;
		n_jump = 0;
		instr_ch.valid = 1'b0;
		instr_ch.cmd = CMD_ADD;
		instr_ch.dest_reg = '0;
		instr_ch.first_source = '0;
		instr_ch.second_source = '0;
		instr_ch.immediate = '0;
		result_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: registers are all zero, so this divide is rejected
		send_instr(CMD_DIV, 3'd1, 3'd0, 3'd0, $urandom);
		send_instr(CMD_LI, 3'd1, 3'd0, 3'd0, 32'h7FFF_FFFF);
		send_instr(CMD_LI, 3'd2, 3'd7, 3'd7, 32'h8000_0000);
		send_instr(CMD_LI, 3'd3, 3'd0, 3'd0, 32'hFFFF_FFFF);
		send_instr(CMD_LI, 3'd4, 3'd0, 3'd0, 32'h0000_0000);
		send_instr(CMD_ADD, 3'd5, 3'd1, 3'd1, $urandom);
		send_instr(CMD_SUB, 3'd6, 3'd2, 3'd1, $urandom);
		send_instr(CMD_MUL, 3'd7, 3'd1, 3'd1, $urandom);
		send_instr(CMD_MUL, 3'd5, 3'd2, 3'd3, $urandom);
		send_instr(CMD_DIV, 3'd6, 3'd2, 3'd3, $urandom);
		send_instr(CMD_DIV, 3'd7, 3'd1, 3'd3, $urandom);
		send_instr(CMD_LI, 3'd5, 3'd0, 3'd0, -32'sd7);
		send_instr(CMD_LI, 3'd6, 3'd0, 3'd0, 32'd2);
		send_instr(CMD_DIV, 3'd7, 3'd5, 3'd6, $urandom);
		send_instr(CMD_DIV, 3'd0, 3'd6, 3'd5, $urandom);
		send_instr(CMD_DIV, 3'd0, 3'd1, 3'd4, $urandom);
		send_instr(CMD_ADDI, 3'd0, 3'd1, 3'd0, 32'd1);
		send_instr(CMD_ADDI, 3'd0, 3'd2, 3'd0, 32'h8000_0000);
		send_instr(CMD_RSVD, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF);
		send_instr(CMD_J, 3'd7, 3'd7, 3'd7, $urandom);
		send_instr(CMD_ADD, 3'd7, 3'd7, 3'd7, $urandom);
		send_instr(CMD_ADDI, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF);
		send_instr(CMD_LI, 3'd0, 3'd0, 3'd0, 32'h5A5A_5A5A);
		send_instr(CMD_LI, 3'd0, 3'd0, 3'd0, 32'hA5A5_A5A5);

		// long back-to-back stretch with no idling on either channel
		idle_on <= 1'b0;
		send_instr(CMD_J, 3'd0, 3'd0, 3'd0, $urandom);
		repeat (BURST_ITEMS) send_random(1'b1);
		send_instr(CMD_MUL, 3'd1, 3'd2, 3'd3, $urandom);
		send_instr(CMD_DIV, 3'd1, 3'd2, 3'd4, $urandom);
		idle_on <= 1'b1;

		repeat (RANDOM_ITEMS) send_random(1'b0);
		instr_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (48) @(posedge clk);

		$display("Ran %0d instructions: %0d mul, %0d div (%0d by zero), %0d jumps.",
			n_items, n_mul, n_div, rejected_divs, n_jump);
		$display("Counter peak %0d; random idles on both channels outside the long stretch.",
			peak_count);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
